### src/ofa_pkg.sv
// shared types, constants and helpers for the one's-complement float adder
package ofa_pkg;

  localparam logic [10:0] EXP_IND   = 11'o1777;
  localparam logic [10:0] EXP_OVR   = 11'o3777;
  localparam logic [11:0] EXP_BIAS  = 12'o2000;
  localparam logic signed [11:0] DBL_FLOOR = 12'sd975;  // 1717 octal
  localparam logic signed [11:0] DBL_SHIFT = 12'sd48;

  // classified item passed from front to back
  typedef struct packed {
    logic                special;
    logic [59:0]         special_word;
    logic [47:0]         big_coef;
    logic                big_neg;
    logic [47:0]         small_coef;
    logic                small_neg;
    logic [10:0]         shift_dist;
    logic signed [11:0]  eres;
    logic                rbit;
    logic                rnd;
    logic                dbl;
  } ofa_item_t;

  // biased exponent field to signed unbiased value
  function automatic logic signed [11:0] unbias(input logic [10:0] e);
    logic signed [11:0] t;
    t = $signed({1'b0, e}) - $signed(EXP_BIAS);
    return (t < 0) ? t + 12'sd1 : t;
  endfunction

  // signed unbiased exponent back to an 11-bit biased field
  function automatic logic [10:0] rebias(input logic signed [11:0] e);
    logic signed [11:0] t;
    t = e + $signed(EXP_BIAS) - ((e < 0) ? 12'sd1 : 12'sd0);
    return t[10:0];
  endfunction

endpackage

### src/ofa_front.sv
// front part: magnitudes, special operands, alignment distance
module ofa_front (
  input  logic [59:0]       operand_a,
  input  logic [59:0]       operand_b,
  input  logic              round_enable,
  input  logic              double_precision,
  output ofa_pkg::ofa_item_t item
);
  import ofa_pkg::*;

  logic [59:0]        a_m, b_m;
  logic               sa, sb;
  logic [10:0]        ea, eb;
  logic signed [11:0] ua, ub, diff;
  logic               a_big;

  always_comb begin
    sa   = operand_a[59];
    sb   = operand_b[59];
    a_m  = operand_a ^ {60{sa}};
    b_m  = operand_b ^ {60{sb}};
    ea   = a_m[58:48];
    eb   = b_m[58:48];
    ua   = unbias(ea);
    ub   = unbias(eb);
    a_big = (ua > ub);
    diff = a_big ? (ua - ub) : (ub - ua);

    item.special      = 1'b0;
    item.special_word = '0;
    if ((ea & EXP_IND) == EXP_IND) begin
      item.special = 1'b1;
      if (ea == EXP_IND || eb == EXP_IND || (eb == EXP_OVR && sa != sb)) begin
        item.special_word = {1'b0, EXP_IND, 48'b0};
      end else begin
        item.special_word = sa ? {1'b1, 59'b0} : {1'b0, EXP_OVR, 48'b0};
      end
    end else if ((eb & EXP_IND) == EXP_IND) begin
      item.special = 1'b1;
      if (eb == EXP_IND) begin
        item.special_word = {1'b0, EXP_IND, 48'b0};
      end else begin
        item.special_word = sb ? {1'b1, 59'b0} : {1'b0, EXP_OVR, 48'b0};
      end
    end

    item.big_coef   = a_big ? a_m[47:0] : b_m[47:0];
    item.big_neg    = a_big ? sa : sb;
    item.small_coef = a_big ? b_m[47:0] : a_m[47:0];
    item.small_neg  = a_big ? sb : sa;
    item.shift_dist = diff[10:0];
    item.eres       = a_big ? ua : ub;
    item.rbit       = round_enable & ((a_m[47] & b_m[47]) | (sa ^ sb));
    item.rnd        = round_enable;
    item.dbl        = double_precision;
  end

endmodule

### src/ofa_queue.sv
// short queue between front and back
module ofa_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ofa_pkg::ofa_item_t wr_item,
  output logic               full,
  input  logic               rd_en,
  output ofa_pkg::ofa_item_t rd_item,
  output logic               not_empty
);
  import ofa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  ofa_item_t     mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == FULLC);
  assign not_empty = (cnt_r != '0);
  assign rd_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/ofa_back.sv
// back part: align and add stage, then carry, normalise and pack stage
module ofa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ext_model,
  input  logic               in_valid,
  input  ofa_pkg::ofa_item_t in_item,
  output logic               in_take,
  output logic               out_valid,
  output logic [59:0]        out_word,
  input  logic               out_take
);
  import ofa_pkg::*;

  // stage 1 registers
  logic               v1_r;
  logic               sp1_r;
  logic [59:0]        spw1_r;
  logic [50:0]        hi1_r;
  logic [48:0]        lo1_r;
  logic signed [11:0] e1_r;
  logic               dbl1_r;
  // output registers
  logic               v2_r;
  logic [59:0]        word2_r;

  logic        adv2, adv1;
  logic [95:0] xv, xs;
  logic [49:0] hi, hiadd;
  logic [47:0] lo, loadd;
  logic [50:0] hi1_nxt;
  logic [48:0] lo1_nxt;

  assign adv2      = v1_r && (!v2_r || out_take);
  assign adv1      = !v1_r || adv2;
  assign in_take   = in_valid && adv1;
  assign out_valid = v2_r;
  assign out_word  = word2_r;

  // align the smaller coefficient and add into the two adder halves
  always_comb begin
    hi    = {2'b0, in_item.big_coef} ^ {50{in_item.big_neg}};
    lo    = {48{in_item.big_neg}} ^ {in_item.rnd, 47'b0};
    xv    = {in_item.small_coef, in_item.rbit, 47'b0};
    xs    = (in_item.shift_dist >= 11'd96) ? '0 : (xv >> in_item.shift_dist[6:0]);
    hiadd = {2'b0, xs[95:48]} ^ {50{in_item.small_neg}};
    loadd = xs[47:0] ^ {48{in_item.small_neg}};
    hi1_nxt = {1'b0, hi} + {1'b0, hiadd};
    lo1_nxt = {1'b0, lo} + {1'b0, loadd};
  end

  // carries, end-around carry, post-normalise and pack
  logic [51:0]        hi2, t2, hi3w;
  logic [47:0]        lo2, lo3, lf, lo_n;
  logic [48:0]        lo3w;
  logic [1:0]         c_ea;
  logic               neg;
  logic [49:0]        hf;
  logic signed [11:0] er_n;
  logic [59:0]        word2_nxt;

  always_comb begin
    hi2  = {1'b0, hi1_r} + {51'b0, lo1_r[48]};
    lo2  = lo1_r[47:0];
    t2   = hi2 + {51'b0, &lo2};
    c_ea = t2[51:50];
    lo3w = {1'b0, lo2} + {47'b0, c_ea};
    hi3w = hi2 + {51'b0, lo3w[48]};
    lo3  = lo3w[47:0];
    neg  = hi3w[49];
    hf   = hi3w[49:0] ^ {50{neg}};
    lf   = lo3 ^ {48{neg}};
    er_n = e1_r + {11'b0, hf[48]};
    lo_n = hf[48] ? {hf[0], lf[47:1]} : lf;
    if (sp1_r) begin
      word2_nxt = spw1_r;
    end else if (dbl1_r) begin
      if ((ext_model && e1_r < -DBL_FLOOR) || er_n < -DBL_FLOOR) begin
        word2_nxt = '0;
      end else begin
        word2_nxt = {1'b0, rebias(er_n - DBL_SHIFT), lo_n} ^ {60{neg}};
      end
    end else begin
      word2_nxt = {1'b0, rebias(er_n), (hf[48] ? hf[48:1] : hf[47:0])} ^ {60{neg}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sp1_r  <= in_item.special;
      spw1_r <= in_item.special_word;
      hi1_r  <= hi1_nxt;
      lo1_r  <= lo1_nxt;
      e1_r   <= in_item.eres;
      dbl1_r <= in_item.dbl;
    end
    if (adv2) begin
      word2_r <= word2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= 1'b1;
      end else if (out_take) begin
        v2_r <= 1'b0;
      end
    end
  end

endmodule

### src/ones_complement_float_add.sv
// top level of the one's-complement floating adder
//
//  channel   direction  handshake          payload
//  in_       push side  in_push / in_full  in_operand_a, in_operand_b, in_round_enable,
//                                          in_double_precision
//  out_      pop side   out_pop / out_empty out_sum_word
//  cfg_      apb        cfg_psel/penable   register 0: extended_float_model (bit 0)
//
// one item a cycle sustained while out_pop keeps taking results; the result shows on the output
// after these registers in order: queue write at the accepting edge, align-and-add stage, pack stage
// synchronous active-low reset empties the queue and pipeline, model bit cleared
// a stalled output holds its item while the queue keeps taking new items
// until it fills
module ones_complement_float_add #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic [59:0] in_operand_a,
  input  logic [59:0] in_operand_b,
  input  logic        in_round_enable,
  input  logic        in_double_precision,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [59:0] out_sum_word,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ofa_pkg::*;

  logic      ext_model_r;
  ofa_item_t front_item, queue_item;
  logic      q_full, q_avail, q_take, out_valid, wr_en;

  // register 0 sits at byte address 0, register bit 0 only
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'b0, ext_model_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_model_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      ext_model_r <= cfg_pwdata[0];
    end
  end

  // classify the incoming item
  ofa_front u_front (
    .operand_a        (in_operand_a),
    .operand_b        (in_operand_b),
    .round_enable     (in_round_enable),
    .double_precision (in_double_precision),
    .item             (front_item)
  );

  assign in_full = q_full;
  assign wr_en   = in_push && !q_full;

  // decouples acceptance from the arithmetic pipeline
  ofa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_item   (front_item),
    .full      (q_full),
    .rd_en     (q_take),
    .rd_item   (queue_item),
    .not_empty (q_avail)
  );

  // arithmetic pipeline with the output register at its end
  ofa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ext_model (ext_model_r),
    .in_valid  (q_avail),
    .in_item   (queue_item),
    .in_take   (q_take),
    .out_valid (out_valid),
    .out_word  (out_sum_word),
    .out_take  (out_pop)
  );

  assign out_empty = !out_valid;

endmodule
